### hw/rtl/bcd_calendar_hour_step_core_defines.svh
// assertion macros for the bcd calendar hour step core
// used by the top level only; needs i_clk and i_rst_n in scope
`ifndef BCD_CALENDAR_HOUR_STEP_CORE_DEFINES_SVH
`define BCD_CALENDAR_HOUR_STEP_CORE_DEFINES_SVH

// checked outside reset
`define BCHS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked through reset as well
`define BCHS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/bchs_pkg.sv
// types, constants and bcd helper functions for the calendar hour step core
// no dependencies
`default_nettype none

package bchs_pkg;

    localparam int unsigned HourW  = 6;
    localparam int unsigned DayW   = 6;
    localparam int unsigned MonthW = 5;
    localparam int unsigned YearW  = 8;

    localparam logic [7:0] HourTop  = 8'h23;
    localparam logic [7:0] MonthTop = 8'h12;
    localparam logic [7:0] YearTop  = 8'h99;
    localparam logic [7:0] DayFirst = 8'h01;
    localparam logic [7:0] Day28    = 8'h28;
    localparam logic [7:0] Day29    = 8'h29;
    localparam logic [7:0] Day30    = 8'h30;
    localparam logic [7:0] Day31    = 8'h31;
    localparam logic [7:0] TensStep = 8'h10;

    localparam logic KindUp   = 1'b0;
    localparam logic KindDown = 1'b1;

    typedef struct packed {
        logic [HourW-1:0]  hour;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } t_date;

    function automatic logic [7:0] bcd_up(input logic [7:0] v);
        logic [7:0] res;
        if (v[3:0] >= 4'd9) begin
            res = {v[7:4], 4'h0} + TensStep;
        end else begin
            res = v + 8'd1;
        end
        return res;
    endfunction

    function automatic logic [7:0] bcd_down(input logic [7:0] v);
        logic [7:0] res;
        if (v[3:0] == 4'h0) begin
            res = v - 8'd7;
        end else begin
            res = v - 8'd1;
        end
        return res;
    endfunction

    // tens*10+units mod 4 equals 2*tens+units mod 4
    function automatic logic is_leap(input logic [7:0] year);
        logic [5:0] s;
        s = {1'b0, year[7:4], 1'b0} + {2'b00, year[3:0]};
        return (s[1:0] == 2'b00);
    endfunction

    function automatic logic [7:0] last_day(input logic [4:0] month, input logic [7:0] year);
        logic [4:0] m;
        logic [7:0] res;
        m = month[4] ? (month - 5'd6) : month;
        case (m)
            5'd1:    res = Day31;
            5'd2:    res = Day28;
            5'd3:    res = Day31;
            5'd4:    res = Day30;
            5'd5:    res = Day31;
            5'd6:    res = Day30;
            5'd7:    res = Day31;
            5'd8:    res = Day31;
            5'd9:    res = Day30;
            5'd10:   res = Day31;
            5'd11:   res = Day30;
            default: res = Day31;
        endcase
        if (is_leap(year) && month == 5'h02) begin
            res = Day29;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bchs_step.sv
// one-hour step of a bcd date, forward or back, as combinational logic
// depends on bchs_pkg for the date type and bcd helpers
`default_nettype none

module bchs_step (
    input  wire logic           i_kind,
    input  wire bchs_pkg::t_date i_date,
    output bchs_pkg::t_date     o_date
);

    logic [7:0] hour8, day8, month8, year8;
    logic [7:0] fwd_last, bwd_last;
    logic       h_wrap, d_wrap, m_wrap;
    logic       h_borrow, d_borrow, m_borrow;
    logic [7:0] up_hour, up_day, up_month, up_year;
    logic [7:0] dn_hour, dn_day, dn_month, dn_year;
    logic [7:0] res_hour, res_day, res_month, res_year;

    always_comb begin
        hour8  = {2'b00, i_date.hour};
        day8   = {2'b00, i_date.day};
        month8 = {3'b000, i_date.month};
        year8  = i_date.year;

        // forward carry chain
        fwd_last = bchs_pkg::last_day(i_date.month, i_date.year);
        h_wrap   = (hour8 >= bchs_pkg::HourTop);
        d_wrap   = h_wrap && (day8 >= fwd_last);
        m_wrap   = d_wrap && (month8 >= bchs_pkg::MonthTop);
        up_hour  = h_wrap ? 8'h00 : bchs_pkg::bcd_up(hour8);
        up_day   = !h_wrap ? day8 :
                   (day8 >= fwd_last) ? bchs_pkg::DayFirst : bchs_pkg::bcd_up(day8);
        up_month = !d_wrap ? month8 :
                   (month8 >= bchs_pkg::MonthTop) ? bchs_pkg::DayFirst : bchs_pkg::bcd_up(month8);
        up_year  = !m_wrap ? year8 :
                   (year8 >= bchs_pkg::YearTop) ? 8'h00 : bchs_pkg::bcd_up(year8);

        // backward borrow chain, day below 01 takes the previous month's length
        h_borrow = (hour8 == 8'h00);
        d_borrow = h_borrow && (day8 <= bchs_pkg::DayFirst);
        m_borrow = d_borrow && (month8 <= bchs_pkg::DayFirst);
        dn_hour  = h_borrow ? bchs_pkg::HourTop : bchs_pkg::bcd_down(hour8);
        dn_month = !d_borrow ? month8 :
                   (month8 <= bchs_pkg::DayFirst) ? bchs_pkg::MonthTop : bchs_pkg::bcd_down(month8);
        dn_year  = !m_borrow ? year8 :
                   (year8 == 8'h00) ? bchs_pkg::YearTop : bchs_pkg::bcd_down(year8);
        bwd_last = bchs_pkg::last_day(dn_month[4:0], dn_year);
        dn_day   = !h_borrow ? day8 : d_borrow ? bwd_last : bchs_pkg::bcd_down(day8);

        if (i_kind == bchs_pkg::KindDown) begin
            res_hour  = dn_hour;
            res_day   = dn_day;
            res_month = dn_month;
            res_year  = dn_year;
        end else begin
            res_hour  = up_hour;
            res_day   = up_day;
            res_month = up_month;
            res_year  = up_year;
        end

        o_date.hour  = res_hour[bchs_pkg::HourW-1:0];
        o_date.day   = res_day[bchs_pkg::DayW-1:0];
        o_date.month = res_month[bchs_pkg::MonthW-1:0];
        o_date.year  = res_year;
    end

endmodule

`default_nettype wire

### hw/rtl/bcd_calendar_hour_step_core.sv
// bcd calendar hour step core: moves a bcd date and hour one hour on or back
//
// input channel: i_valid / o_ready carry one word of kind, hour, day, month
//   and year; kind low steps forward, kind high steps back
// output channel: o_valid / i_ready carry the stepped hour, day, month, year
// path: one input register and one result register with the step logic
//   between them; an accepted word is stepped on its way from the first
//   into the second, and o_valid rises once it reaches the result register
// throughput: one word per cycle while the receiver keeps i_ready high
// stall: with i_ready low the result register holds its word, the input
//   register still fills, and o_ready drops only once both are occupied
// reset: i_rst_n low at a clock edge empties both registers; o_valid is low
//   and o_ready high in the cycle after
// depends on bchs_pkg, bchs_step and the assertion macro header
`default_nettype none
`include "bcd_calendar_hour_step_core_defines.svh"

module bcd_calendar_hour_step_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_kind,
    input  wire logic [5:0] i_hour_in,
    input  wire logic [5:0] i_day_in,
    input  wire logic [4:0] i_month_in,
    input  wire logic [7:0] i_year_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [5:0]      o_hour_out,
    output logic [5:0]      o_day_out,
    output logic [4:0]      o_month_out,
    output logic [7:0]      o_year_out
);

    logic            r_s1_valid, n_s1_valid;
    logic            r_kind;
    bchs_pkg::t_date r_in_date;
    logic            r_o_valid, n_o_valid;
    bchs_pkg::t_date r_out_date;
    bchs_pkg::t_date step_date;
    logic            s1_move;
    logic            in_take;

    bchs_step u_step (
        .i_kind (r_kind),
        .i_date (r_in_date),
        .o_date (step_date)
    );

    // result register frees up when empty or being taken
    assign s1_move = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign in_take = i_valid && o_ready;

    always_comb begin
        n_s1_valid = in_take || (r_s1_valid && !s1_move);
        n_o_valid  = s1_move || (r_o_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind          <= i_kind;
            r_in_date.hour  <= i_hour_in;
            r_in_date.day   <= i_day_in;
            r_in_date.month <= i_month_in;
            r_in_date.year  <= i_year_in;
        end
        if (s1_move) begin
            r_out_date <= step_date;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_hour_out  = r_out_date.hour;
    assign o_day_out   = r_out_date.day;
    assign o_month_out = r_out_date.month;
    assign o_year_out  = r_out_date.year;

    `BCHS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid && o_ready, "reset must empty the core")
    `BCHS_ASSERT(a_s1_fills_out, r_s1_valid && !o_valid |=> o_valid, "stepped word not moved out")
    `BCHS_ASSERT(a_full_stall, r_s1_valid && o_valid && !i_ready |-> !o_ready, "input taken while full")
    `BCHS_ASSERT(a_drain, o_valid && i_ready && !r_s1_valid |=> !o_valid, "result word repeated")

endmodule

`default_nettype wire

### bench/date_step_checker.sv
`timescale 1ns / 100ps
// checker for the bcd calendar hour step core: watches both channels,
// works out the stepped date of every accepted word and compares results
// depends on bchs_pkg for the date struct, step kinds and calendar constants

module date_step_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_kind,
    input  logic [5:0] i_hour_in,
    input  logic [5:0] i_day_in,
    input  logic [4:0] i_month_in,
    input  logic [7:0] i_year_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [5:0] i_hour_out,
    input  logic [5:0] i_day_out,
    input  logic [4:0] i_month_out,
    input  logic [7:0] i_year_out,
    output int         o_fail_count,
    output int         o_pending
);

    bchs_pkg::t_date due_dates[$];
    int    fail_count = 0;
    int    pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [7:0] digit_inc(input logic [7:0] v);
        if (v[3:0] >= 4'd9) begin
            return {v[7:4] + 4'd1, 4'h0};
        end
        return v + 8'd1;
    endfunction

    function automatic logic [7:0] digit_dec(input logic [7:0] v);
        if (v[3:0] == 4'h0) begin
            return v - 8'd7;
        end
        return v - 8'd1;
    endfunction

    // leap test on the binary value of the two digits, whatever they hold
    function automatic logic leap_by_value(input logic [7:0] yr);
        int unsigned v;
        v = yr[7:4] * 10 + yr[3:0];
        return (v % 4) == 0;
    endfunction

    function automatic logic [7:0] days_in_month(input logic [4:0] mo, input logic [7:0] yr);
        logic [4:0] pos;
        if (mo == 5'h02 && leap_by_value(yr)) begin
            return bchs_pkg::Day29;
        end
        // bcd 0x10..0x1f folds down to positions 10..25
        pos = mo[4] ? mo - 5'd6 : mo;
        case (pos)
            5'd2:                     return bchs_pkg::Day28;
            5'd4, 5'd6, 5'd9, 5'd11: return bchs_pkg::Day30;
            default:                  return bchs_pkg::Day31;
        endcase
    endfunction

    function automatic bchs_pkg::t_date next_hour_date(input logic kind,
                                                       input bchs_pkg::t_date now);
        logic [7:0]      hr, dy, mo, yr;
        bchs_pkg::t_date res;
        hr = 8'(now.hour);
        dy = 8'(now.day);
        mo = 8'(now.month);
        yr = now.year;
        if (kind == bchs_pkg::KindUp) begin
            if (hr >= bchs_pkg::HourTop) begin
                hr = 8'h00;
                if (dy >= days_in_month(mo[4:0], yr)) begin
                    dy = bchs_pkg::DayFirst;
                    if (mo >= bchs_pkg::MonthTop) begin
                        mo = 8'h01;
                        yr = (yr >= bchs_pkg::YearTop) ? 8'h00 : digit_inc(yr);
                    end else begin
                        mo = digit_inc(mo);
                    end
                end else begin
                    dy = digit_inc(dy);
                end
            end else begin
                hr = digit_inc(hr);
            end
        end else begin
            if (hr == 8'h00) begin
                hr = bchs_pkg::HourTop;
                // day 00 borrows like day 01
                if (dy <= bchs_pkg::DayFirst) begin
                    if (mo <= 8'h01) begin
                        mo = bchs_pkg::MonthTop;
                        yr = (yr == 8'h00) ? bchs_pkg::YearTop : digit_dec(yr);
                    end else begin
                        mo = digit_dec(mo);
                    end
                    dy = days_in_month(mo[4:0], yr);
                end else begin
                    dy = digit_dec(dy);
                end
            end else begin
                hr = digit_dec(hr);
            end
        end
        res.hour  = hr[5:0];
        res.day   = dy[5:0];
        res.month = mo[4:0];
        res.year  = yr;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        bchs_pkg::t_date now;
        bchs_pkg::t_date want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                now.hour  = i_hour_in;
                now.day   = i_day_in;
                now.month = i_month_in;
                now.year  = i_year_in;
                due_dates.push_back(next_hour_date(i_kind, now));
            end
            if (i_out_valid && i_out_ready) begin
                if (due_dates.size() == 0) begin
                    $error("result word with no step outstanding");
                    fail_count++;
                end else begin
                    want = due_dates.pop_front();
                    compare_field("hour_out", 8'(want.hour), 8'(i_hour_out));
                    compare_field("day_out", 8'(want.day), 8'(i_day_out));
                    compare_field("month_out", 8'(want.month), 8'(i_month_out));
                    compare_field("year_out", want.year, i_year_out);
                end
            end
        end
        pending = due_dates.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// top of the bench for the bcd calendar hour step core: clock, reset,
// directed and random date words, handshake idling and the verdict
// depends on bchs_pkg, the core and date_step_checker

module testbench;

    localparam int HoldCycles = 300;
    localparam int IdleLimit  = 5000;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       i_kind     = bchs_pkg::KindUp;
    logic [5:0] i_hour_in  = '0;
    logic [5:0] i_day_in   = 6'h01;
    logic [4:0] i_month_in = 5'h01;
    logic [7:0] i_year_in  = '0;
    logic       i_ready    = 1'b1;
    logic       o_ready;
    logic       o_valid;
    logic [5:0] o_hour_out;
    logic [5:0] o_day_out;
    logic [4:0] o_month_out;
    logic [7:0] o_year_out;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int quiet_cycles   = 0;

    bcd_calendar_hour_step_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_hour_in   (i_hour_in),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hour_out  (o_hour_out),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out)
    );

    date_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_kind       (i_kind),
        .i_hour_in    (i_hour_in),
        .i_day_in     (i_day_in),
        .i_month_in   (i_month_in),
        .i_year_in    (i_year_in),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_hour_out   (o_hour_out),
        .i_day_out    (o_day_out),
        .i_month_out  (o_month_out),
        .i_year_out   (o_year_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // receiver: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IdleLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [7:0] to_bcd(input int n);
        return 8'((n / 10) * 16 + n % 10);
    endfunction

    task automatic send_word(input logic kind, input logic [5:0] hr, input logic [5:0] dy,
                             input logic [4:0] mo, input logic [7:0] yr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_hour_in  <= hr;
        i_day_in   <= dy;
        i_month_in <= mo;
        i_year_in  <= yr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // mostly well-formed dates piled onto the carry and borrow edges
    task automatic send_random_word();
        int         pick;
        logic       kind;
        logic [7:0] hr, dy, mo, yr;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? bchs_pkg::KindDown : bchs_pkg::KindUp;
        if (pick < 15) begin
            hr = 8'($urandom);
            dy = 8'($urandom);
            mo = 8'($urandom);
            yr = 8'($urandom);
        end else begin
            yr = to_bcd($urandom_range(0, 99));
            mo = to_bcd($urandom_range(1, 12));
            case ($urandom_range(0, 5))
                0:       dy = bchs_pkg::DayFirst;
                1:       dy = bchs_pkg::Day28;
                2:       dy = bchs_pkg::Day29;
                3:       dy = bchs_pkg::Day30;
                4:       dy = bchs_pkg::Day31;
                default: dy = to_bcd($urandom_range(1, 31));
            endcase
            if ($urandom_range(0, 1)) begin
                hr = (kind == bchs_pkg::KindUp) ? bchs_pkg::HourTop : 8'h00;
            end else begin
                hr = to_bcd($urandom_range(0, 23));
            end
        end
        send_word(kind, hr[5:0], dy[5:0], mo[4:0], yr);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_word();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // year, month and day wraps both ways
        send_word(bchs_pkg::KindUp,   6'h23, 6'h31, 5'h12, 8'h99);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h01, 8'h00);
        // february in leap and common years
        send_word(bchs_pkg::KindUp,   6'h23, 6'h28, 5'h02, 8'h24);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h28, 5'h02, 8'h23);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h29, 5'h02, 8'h96);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h03, 8'h24);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h03, 8'h00);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h03, 8'h01);
        // thirty-day months
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h05, 8'h10);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h30, 5'h04, 8'h10);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h31, 5'h0B, 8'h3A);
        // units carry and borrow
        send_word(bchs_pkg::KindUp,   6'h09, 6'h15, 5'h06, 8'h50);
        send_word(bchs_pkg::KindDown, 6'h10, 6'h15, 5'h06, 8'h50);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h20, 5'h07, 8'h50);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h19, 5'h09, 8'h42);
        // day zero borrows like the first
        send_word(bchs_pkg::KindDown, 6'h00, 6'h00, 5'h08, 8'h50);
        // all ones and all zeros
        send_word(bchs_pkg::KindUp,   6'h3F, 6'h3F, 5'h1F, 8'hFF);
        send_word(bchs_pkg::KindDown, 6'h3F, 6'h3F, 5'h1F, 8'hFF);
        send_word(bchs_pkg::KindUp,   6'h00, 6'h00, 5'h00, 8'h00);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h00, 5'h00, 8'h00);
        // bad digits in hour, month and year
        send_word(bchs_pkg::KindUp,   6'h1A, 6'h09, 5'h0A, 8'h0C);
        send_word(bchs_pkg::KindUp,   6'h23, 6'h1C, 5'h1C, 8'h1C);
        send_word(bchs_pkg::KindDown, 6'h00, 6'h01, 5'h1A, 8'h1C);

        run_phase(0, 0, 350);
        run_phase(67, 0, 350);
        run_phase(0, 67, 350);
        run_phase(14, 14, 350);
        // long receiver hold-off while words keep coming
        hold_req = 1'b1;
        run_phase(0, 0, 150);
        run_phase(0, 0, 330);

        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
